[rtl/lesf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesf_pkg
// shared constants and types of the largest empty square finder
// ----------------------------------------------------------------------------
package lesf_pkg;

  localparam int unsigned MAX_COLS   = 1024;
  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0]  EMPTY_CODE_RST = CODE_W'(46);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST  = WIDTH_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMPTY_CODE = 1'b0,
    REG_ROW_WIDTH  = 1'b1
  } cfg_reg_e;

  // one classified cell on its way to the recurrence
  typedef struct packed {
    logic             free;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             use_up;
    logic             ovf;
  } lesf_item_t;

endpackage

`default_nettype wire

[rtl/lesf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesf_front
// configuration registers, cell classification and row/column tracking
// ----------------------------------------------------------------------------
module lesf_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lesf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lesf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_fire_i,
  input  wire logic [lesf_pkg::CODE_W-1:0]       cell_code_i,
  input  wire logic                              last_cell_i,
  output lesf_pkg::lesf_item_t                   item_o
);

  localparam int unsigned RL_W = lesf_pkg::ROW_W + 1;
  localparam logic [RL_W-1:0] ROWS_LIM = RL_W'(lesf_pkg::MAX_ROWS);

  logic [lesf_pkg::CODE_W-1:0]  empty_q;
  logic [lesf_pkg::WIDTH_W-1:0] width_q;
  logic [lesf_pkg::WIDTH_W-1:0] eff_w;

  logic [lesf_pkg::COL_W-1:0] col_q, col_d, col_a;
  logic [lesf_pkg::ROW_W-1:0] row_q, row_d, row_a;
  logic                       ovf_q, ovf_d, ovf_a;
  logic [lesf_pkg::WIDTH_W-1:0] col_n;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= lesf_pkg::EMPTY_CODE_RST;
      width_q <= lesf_pkg::ROW_WIDTH_RST;
    end else if (cfg_valid_i) begin
      unique case (lesf_pkg::cfg_reg_e'(cfg_index_i))
        lesf_pkg::REG_EMPTY_CODE: empty_q <= cfg_data_i[lesf_pkg::CODE_W-1:0];
        lesf_pkg::REG_ROW_WIDTH:  width_q <= cfg_data_i[lesf_pkg::WIDTH_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = lesf_pkg::WIDTH_W'(1);
    end else if (width_q > lesf_pkg::WIDTH_W'(lesf_pkg::MAX_COLS)) begin
      eff_w = lesf_pkg::WIDTH_W'(lesf_pkg::MAX_COLS);
    end else begin
      eff_w = width_q;
    end
  end

  always_comb begin
    // a narrowed row width may close the current row before this cell
    col_a = col_q;
    row_a = row_q;
    ovf_a = ovf_q;
    if (lesf_pkg::WIDTH_W'(col_q) >= eff_w) begin
      col_a = '0;
      if ((RL_W'(row_q) + RL_W'(1)) >= ROWS_LIM) begin
        ovf_a = 1'b1;
      end else begin
        row_a = row_q + 1'b1;
      end
    end

    item_o.free   = (cell_code_i == empty_q);
    item_o.last   = last_cell_i;
    item_o.col    = col_a;
    item_o.row    = row_a;
    item_o.use_up = (row_a != '0) || ovf_a;
    item_o.ovf    = ovf_a;

    col_n = lesf_pkg::WIDTH_W'(col_a) + lesf_pkg::WIDTH_W'(1);
    col_d = col_n[lesf_pkg::COL_W-1:0];
    row_d = row_a;
    ovf_d = ovf_a;
    if (col_n >= eff_w) begin
      col_d = '0;
      if ((RL_W'(row_a) + RL_W'(1)) >= ROWS_LIM) begin
        ovf_d = 1'b1;
      end else begin
        row_d = row_a + 1'b1;
      end
    end
    if (last_cell_i) begin
      col_d = '0;
      row_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ovf_q <= 1'b0;
    end else if (in_fire_i) begin
      col_q <= col_d;
      row_q <= row_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lesf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesf_queue
// two-entry queue of classified cells between front and back
// ----------------------------------------------------------------------------
module lesf_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  lesf_pkg::lesf_item_t       push_item_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output lesf_pkg::lesf_item_t       head_o,
  output logic                       head_valid_o
);

  localparam int unsigned PTR_W = $clog2(lesf_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(lesf_pkg::QUEUE_DEPTH + 1);

  lesf_pkg::lesf_item_t entry_q [lesf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == CNT_W'(lesf_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lesf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesf_back
// row buffer, maximal-square recurrence, best square tracking and result
// ----------------------------------------------------------------------------
module lesf_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  lesf_pkg::lesf_item_t                      head_i,
  input  wire logic                                 head_valid_i,
  output logic                                      pop_o,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // square_size[10:0], top_row[20:11], top_col[30:21], zero pad[31]
  output logic [lesf_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // too_many_rows[0]
  output logic                                      m_axis_tuser
);

  localparam int unsigned SW = lesf_pkg::SIZE_W;
  localparam int unsigned PW = lesf_pkg::POS_W;

  logic [SW-1:0] mem [lesf_pkg::MAX_COLS];

  lesf_pkg::lesf_item_t b_q;
  logic          b_valid_q;
  logic          b_done;
  logic [SW-1:0] rdata_q;
  logic          fwd_q;
  logic [SW-1:0] fwd_val_q;

  logic [SW-1:0] left_q, diag_q;
  logic [SW-1:0] up, left_v, diag_v, min_ld, min3, s;

  logic [SW-1:0]                best_size_q, best_size_d;
  logic [lesf_pkg::ROW_W-1:0]   best_row_q, best_row_d;
  logic [lesf_pkg::COL_W-1:0]   best_col_q, best_col_d;

  logic          out_valid_q;
  logic [SW-1:0] out_size_q;
  logic [PW-1:0] out_row_q, out_col_q;
  logic          out_ovf_q;
  logic [SW-1:0] row_end, col_end;
  logic [PW-1:0] top_row, top_col;

  assign b_done = b_valid_q && (!b_q.last || !out_valid_q || m_axis_tready);
  assign pop_o  = head_valid_i && (!b_valid_q || b_done);

  always_comb begin
    up     = b_q.use_up ? (fwd_q ? fwd_val_q : rdata_q) : '0;
    left_v = (b_q.col == '0) ? '0 : left_q;
    diag_v = (b_q.col == '0) ? '0 : diag_q;
    min_ld = (left_v < diag_v) ? left_v : diag_v;
    min3   = (up < min_ld) ? up : min_ld;
    s      = b_q.free ? (min3 + 1'b1) : '0;

    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if (s > best_size_q) begin
      best_size_d = s;
      best_row_d  = b_q.row;
      best_col_d  = b_q.col;
    end

    row_end = SW'(best_row_d) + 1'b1;
    col_end = SW'(best_col_d) + 1'b1;
    top_row = '0;
    top_col = '0;
    if (best_size_d != '0) begin
      if (row_end >= best_size_d) begin
        top_row = PW'(row_end - best_size_d);
      end
      if (col_end >= best_size_d) begin
        top_col = PW'(col_end - best_size_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_done) begin
      mem[b_q.col] <= s;
    end
    if (pop_o) begin
      rdata_q <= mem[head_i.col];
      b_q     <= head_i;
    end
    fwd_val_q <= s;
    if (b_done && b_q.last) begin
      out_size_q <= best_size_d;
      out_row_q  <= top_row;
      out_col_q  <= top_col;
      out_ovf_q  <= b_q.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q <= 1'b1;
        // same column written by the cell now leaving the stage
        fwd_q     <= b_done && (head_i.col == b_q.col);
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end
      if (b_done) begin
        left_q <= s;
        diag_q <= up;
        if (b_q.last) begin
          best_size_q <= '0;
          best_row_q  <= '0;
          best_col_q  <= '0;
        end else begin
          best_size_q <= best_size_d;
          best_row_q  <= best_row_d;
          best_col_q  <= best_col_d;
        end
      end
      if (b_done && b_q.last) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_col_q, out_row_q, out_size_q};
  assign m_axis_tuser  = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(b_done && b_q.last))
    else $error("result raised without a last cell");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(b_done))
    else $error("forwarded size without a buffer write");

  a_no_square_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_size_q == '0) |-> (out_row_q == '0 && out_col_q == '0))
    else $error("empty result with non-zero position");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_done && b_q.last) |=> (best_size_q == '0))
    else $error("best square not cleared after result");
`endif

endmodule

`default_nettype wire

[rtl/largest_empty_square_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// streams map cells and reports the largest free square on the last cell
// ----------------------------------------------------------------------------
// One map cell is taken per clock cycle, row-major, with no bubble between
// cells or maps, unless an untaken result stalls the back stage. A cell
// costs one read and one write of the 1024 x 11-bit row buffer in the back
// stage, which sets the rate of one cell a cycle; the result is held in an
// output register while further cells keep flowing. The row buffer needs no
// clearing pass after reset. Write empty_code and row_width only while idle.
module largest_empty_square_finder (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [lesf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [lesf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // cell_code[7:0]
  input  wire logic [lesf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // last_cell
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // square_size[10:0], top_row[20:11], top_col[30:21], zero pad[31]
  output logic [lesf_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // too_many_rows[0]
  output logic                                      m_axis_tuser
);

  logic                 in_fire;
  logic                 q_full;
  logic                 q_pop;
  logic                 head_valid;
  lesf_pkg::lesf_item_t item;
  lesf_pkg::lesf_item_t head;

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  lesf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .cell_code_i (s_axis_tdata[lesf_pkg::CODE_W-1:0]),
    .last_cell_i (s_axis_tlast),
    .item_o      (item)
  );

  lesf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_fire),
    .push_item_i  (item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  lesf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
